// ----- hw/rtl/lfru_expert_slot_cache_unit_macros.svh -----
// Assertion macros shared by the checker of the expert slot cache.
// Both macros expect aclk and aresetn to be visible where they are used.
`ifndef LFRU_EXPERT_SLOT_CACHE_UNIT_MACROS_SVH
`define LFRU_EXPERT_SLOT_CACHE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFRU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LFRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lfru_pkg.sv -----
// Package of the expert slot cache: constants, register indexes and the
// command and status structs between controller and datapath. No dependencies.
package lfru_pkg;

    localparam int DEF_MAX_LAYERS  = 64;
    localparam int BUCKETS         = 4;
    localparam int DEF_MAX_SLOTS   = 16;
    localparam int DEF_EXPERT_BITS = 9;

    localparam int USE_W   = 32;
    localparam int STAMP_W = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [6:0] RST_LAYERS_IN_USE  = 7'd64;
    localparam logic [4:0] RST_SLOTS_PER_CELL = 5'd16;
    localparam logic [9:0] RST_EXPERTS_IN_USE = 10'd512;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYERS_IN_USE  = 2'd0,
        CFG_SLOTS_PER_CELL = 2'd1,
        CFG_EXPERTS_IN_USE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic capture;
        logic scan_start;
        logic scan_step;
        logic commit;
        logic out_load;
    } lfru_cmd_t;

    typedef struct packed {
        logic err;
        logic scan_done;
    } lfru_status_t;

endpackage

// ----- hw/rtl/lfru_ctrl.sv -----
// Controller of the expert slot cache: sequences capture, scan, commit and result.
// Depends on lfru_pkg for the command and status structs.
module lfru_ctrl import lfru_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  lfru_status_t status,
    output lfru_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_COMMIT,
        ST_RESULT
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd            = '0;
        cmd.capture    = (state_reg == ST_IDLE) && s_tvalid;
        cmd.scan_start = (state_reg == ST_LOOKUP) && !status.err;
        cmd.scan_step  = (state_reg == ST_SCAN);
        cmd.commit     = (state_reg == ST_COMMIT);
        cmd.out_load   = (state_reg == ST_RESULT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    state_reg <= status.err ? ST_RESULT : ST_SCAN;
                end
                ST_SCAN: begin
                    if (status.scan_done) begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/lfru_dp.sv -----
// Datapath of the expert slot cache: slot entry memory, fill pointers, scan
// unit with match and victim tracking, stamp counter and result registers.
// Depends on lfru_pkg for constants and the command and status structs.
module lfru_dp import lfru_pkg::*; #(
    parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
    parameter int MAX_SLOTS   = DEF_MAX_SLOTS,
    parameter int EXPERT_BITS = DEF_EXPERT_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [6:0]   layers_in_use,
    input  logic [4:0]   slots_per_cell,
    input  logic [9:0]   experts_in_use,
    input  logic [5:0]   in_layer,
    input  logic [1:0]   in_bucket,
    input  logic [8:0]   in_expert,
    input  lfru_cmd_t    cmd,
    output lfru_status_t status,
    output logic [3:0]   out_slot,
    output logic         out_hit,
    output logic         out_evicted,
    output logic [8:0]   out_evicted_expert,
    output logic         out_error
);

    localparam int CELLS      = MAX_LAYERS * BUCKETS;
    localparam int CELL_W     = $clog2(CELLS);
    localparam int CELL_DEPTH = 1 << CELL_W;
    localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int ADDR_W     = CELL_W + SLOT_W;
    localparam int DEPTH      = 1 << ADDR_W;
    localparam int ENT_W      = STAMP_W + USE_W + EXPERT_BITS;

    logic [ENT_W-1:0]       ent_mem [DEPTH];
    logic [CNT_W-1:0]       fp_mem  [CELL_DEPTH];
    logic [CELL_DEPTH-1:0]  fp_vld_reg;

    logic [CELL_W-1:0]      cell_reg;
    logic [EXPERT_BITS-1:0] id_reg;
    logic [CNT_W-1:0]       n_reg;
    logic                   err_reg;

    logic [CNT_W-1:0]       rd_idx_reg;
    logic [CNT_W-1:0]       chk_idx_reg;
    logic                   rdv_reg;
    logic [ENT_W-1:0]       ent_q_reg;
    logic [CNT_W-1:0]       fp_q_reg;
    logic                   fp_vq_reg;

    logic                   hit_reg;
    logic [CNT_W-1:0]       hit_idx_reg;
    logic [USE_W-1:0]       hit_cnt_reg;
    logic [CNT_W-1:0]       best_idx_reg;
    logic [USE_W-1:0]       best_cnt_reg;
    logic [STAMP_W-1:0]     best_stamp_reg;
    logic [EXPERT_BITS-1:0] best_id_reg;

    logic [STAMP_W-1:0]     gstamp_reg;

    logic [3:0]             res_slot_reg;
    logic                   res_hit_reg;
    logic                   res_evicted_reg;
    logic [8:0]             res_evicted_expert_reg;
    logic                   res_error_reg;

    logic [3:0]             out_slot_reg;
    logic                   out_hit_reg;
    logic                   out_evicted_reg;
    logic [8:0]             out_evicted_expert_reg;
    logic                   out_error_reg;

    logic [9:0]             n_a;
    logic [9:0]             n_b;
    logic [CNT_W-1:0]       n_next;
    logic                   err_next;
    logic                   issue;
    logic [SLOT_W-1:0]      rd_slot;
    logic [ADDR_W-1:0]      rd_addr;
    logic [CNT_W-1:0]       fp_cur;
    logic [EXPERT_BITS-1:0] e_id;
    logic [USE_W-1:0]       e_cnt;
    logic [STAMP_W-1:0]     e_stamp;
    logic                   e_valid;
    logic                   e_match;
    logic                   e_better;
    logic                   fill;
    logic [CNT_W-1:0]       slot_sel;
    logic [USE_W-1:0]       wr_cnt;
    logic [STAMP_W-1:0]     stamp_inc;
    logic [ADDR_W-1:0]      wr_addr;

    always_comb begin
        n_a      = (10'(slots_per_cell) < experts_in_use) ? 10'(slots_per_cell) : experts_in_use;
        n_b      = (n_a > 10'(MAX_SLOTS)) ? 10'(MAX_SLOTS) : n_a;
        n_next   = CNT_W'(n_b);
        err_next = (7'(in_layer) >= layers_in_use) || (9'(in_layer) >= 9'(MAX_LAYERS))
                   || (n_b == 10'd0);
    end

    assign issue   = cmd.scan_start || (cmd.scan_step && (rd_idx_reg < n_reg));
    assign rd_slot = cmd.scan_start ? '0 : rd_idx_reg[SLOT_W-1:0];
    assign rd_addr = {cell_reg, rd_slot};
    assign fp_cur  = fp_vq_reg ? fp_q_reg : '0;

    assign e_id     = ent_q_reg[EXPERT_BITS-1:0];
    assign e_valid  = chk_idx_reg < fp_cur;
    assign e_cnt    = e_valid ? ent_q_reg[EXPERT_BITS +: USE_W] : '0;
    assign e_stamp  = e_valid ? ent_q_reg[EXPERT_BITS + USE_W +: STAMP_W] : '0;
    assign e_match  = e_valid && (e_id == id_reg);
    assign e_better = (chk_idx_reg == '0) || (e_cnt < best_cnt_reg)
                      || ((e_cnt == best_cnt_reg) && (e_stamp < best_stamp_reg));

    assign fill      = fp_cur < n_reg;
    assign slot_sel  = hit_reg ? hit_idx_reg : (fill ? fp_cur : best_idx_reg);
    assign stamp_inc = gstamp_reg + STAMP_W'(1);
    assign wr_cnt    = !hit_reg ? USE_W'(1)
                     : ((hit_cnt_reg == '1) ? hit_cnt_reg : hit_cnt_reg + USE_W'(1));
    assign wr_addr   = {cell_reg, slot_sel[SLOT_W-1:0]};

    assign status.err       = err_reg;
    assign status.scan_done = (rd_idx_reg == n_reg) && !rdv_reg;

    always_ff @(posedge aclk) begin
        if (issue) begin
            ent_q_reg <= ent_mem[rd_addr];
        end
        if (cmd.commit) begin
            ent_mem[wr_addr] <= {stamp_inc, wr_cnt, id_reg};
        end
        if (cmd.scan_start) begin
            fp_q_reg <= fp_mem[cell_reg];
        end
        if (cmd.commit && !hit_reg && fill) begin
            fp_mem[cell_reg] <= fp_cur + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fp_vld_reg <= '0;
            fp_vq_reg  <= 1'b0;
            gstamp_reg <= '0;
            rdv_reg    <= 1'b0;
            rd_idx_reg <= '0;
            err_reg    <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            rdv_reg <= issue;
            if (issue) begin
                chk_idx_reg <= cmd.scan_start ? '0 : rd_idx_reg;
                rd_idx_reg  <= cmd.scan_start ? CNT_W'(1) : rd_idx_reg + CNT_W'(1);
            end
            if (cmd.capture) begin
                err_reg    <= err_next;
                rd_idx_reg <= '0;
            end
            if (cmd.scan_start) begin
                fp_vq_reg <= fp_vld_reg[cell_reg];
                hit_reg   <= 1'b0;
            end
            if (rdv_reg && e_match && !hit_reg) begin
                hit_reg <= 1'b1;
            end
            if (cmd.commit) begin
                gstamp_reg <= stamp_inc;
                if (!hit_reg && fill) begin
                    fp_vld_reg[cell_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cell_reg               <= CELL_W'({in_layer, in_bucket});
            id_reg                 <= EXPERT_BITS'(in_expert);
            n_reg                  <= n_next;
            res_slot_reg           <= '0;
            res_hit_reg            <= 1'b0;
            res_evicted_reg        <= 1'b0;
            res_evicted_expert_reg <= '0;
            res_error_reg          <= err_next;
        end
        if (rdv_reg) begin
            if (e_match && !hit_reg) begin
                hit_idx_reg <= chk_idx_reg;
                hit_cnt_reg <= e_cnt;
            end
            if (e_better) begin
                best_idx_reg   <= chk_idx_reg;
                best_cnt_reg   <= e_cnt;
                best_stamp_reg <= e_stamp;
                best_id_reg    <= e_id;
            end
        end
        if (cmd.commit) begin
            res_slot_reg           <= 4'(slot_sel);
            res_hit_reg            <= hit_reg;
            res_evicted_reg        <= !hit_reg && !fill;
            res_evicted_expert_reg <= (!hit_reg && !fill) ? 9'(best_id_reg) : '0;
        end
        if (cmd.out_load) begin
            out_slot_reg           <= res_slot_reg;
            out_hit_reg            <= res_hit_reg;
            out_evicted_reg        <= res_evicted_reg;
            out_evicted_expert_reg <= res_evicted_expert_reg;
            out_error_reg          <= res_error_reg;
        end
    end

    assign out_slot           = out_slot_reg;
    assign out_hit            = out_hit_reg;
    assign out_evicted        = out_evicted_reg;
    assign out_evicted_expert = out_evicted_expert_reg;
    assign out_error          = out_error_reg;

endmodule

// ----- hw/rtl/lfru_expert_slot_cache_unit.sv -----
// Flow: an accepted access is looked up, its n active slots are scanned one entry per cycle, the
// result is committed and then loaded as the result beat; a new access is accepted only when idle.
// A rejected access skips the scan and the commit and goes from lookup straight to its result beat.
// Reset (synchronous, active low) empties every cell at once through per-cell fill valid bits,
// clears the stamp counter and restores the configuration registers; no clearing pass.
module lfru_expert_slot_cache_unit import lfru_pkg::*; #(
    parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
    parameter int MAX_SLOTS   = DEF_MAX_SLOTS,
    parameter int EXPERT_BITS = DEF_EXPERT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // layer[5:0], bucket[7:6], expert[16:8], zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata    // slot, hit, evicted, evicted_expert, error
);

    logic [6:0]   layers_in_use_reg;
    logic [4:0]   slots_per_cell_reg;
    logic [9:0]   experts_in_use_reg;
    lfru_cmd_t    cmd;
    lfru_status_t status;
    logic [3:0]   out_slot;
    logic         out_hit;
    logic         out_evicted;
    logic [8:0]   out_evicted_expert;
    logic         out_error;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layers_in_use_reg  <= RST_LAYERS_IN_USE;
            slots_per_cell_reg <= RST_SLOTS_PER_CELL;
            experts_in_use_reg <= RST_EXPERTS_IN_USE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LAYERS_IN_USE:  layers_in_use_reg  <= cfg_wdata[6:0];
                CFG_SLOTS_PER_CELL: slots_per_cell_reg <= cfg_wdata[4:0];
                CFG_EXPERTS_IN_USE: experts_in_use_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    lfru_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lfru_dp #(
        .MAX_LAYERS  (MAX_LAYERS),
        .MAX_SLOTS   (MAX_SLOTS),
        .EXPERT_BITS (EXPERT_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .layers_in_use      (layers_in_use_reg),
        .slots_per_cell     (slots_per_cell_reg),
        .experts_in_use     (experts_in_use_reg),
        .in_layer           (s_tdata[5:0]),
        .in_bucket          (s_tdata[7:6]),
        .in_expert          (s_tdata[16:8]),
        .cmd                (cmd),
        .status             (status),
        .out_slot           (out_slot),
        .out_hit            (out_hit),
        .out_evicted        (out_evicted),
        .out_evicted_expert (out_evicted_expert),
        .out_error          (out_error)
    );

    assign m_tdata = {out_error, out_evicted_expert, out_evicted, out_hit, out_slot};

endmodule

// ----- hw/rtl/lfru_checker.sv -----
// Port-level checker of the expert slot cache and its bind to the top level.
// Depends on lfru_expert_slot_cache_unit_macros.svh for the assertion macros.
`include "lfru_expert_slot_cache_unit_macros.svh"

module lfru_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `LFRU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result beat changed")
    `LFRU_ASSERT_NOW(a_err_clean, m_tvalid && m_tdata[15], m_tdata[14:0] == 15'd0, "rejected beat carries data")
    `LFRU_ASSERT_NOW(a_hit_no_evict, m_tvalid, !(m_tdata[4] && m_tdata[5]), "hit and eviction together")
    `LFRU_ASSERT_NOW(a_evict_id, m_tvalid && !m_tdata[5], m_tdata[14:6] == 9'd0, "evicted id without eviction")
    `LFRU_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second beat taken while busy")

endmodule

bind lfru_expert_slot_cache_unit lfru_checker u_lfru_checker (.*);
